>>> src/pat_pkg.sv
// Package for the Paxos acceptor table: payload, command and table entry types,
// operation and state codes, and slot index helpers. No dependencies.
package pat_pkg;

    localparam int INSTANCE_SLOTS = 65536;
    localparam int SLOT_W = $clog2(INSTANCE_SLOTS);
    localparam int PADDR_W = 3;
    localparam logic [15:0] ACCEPTOR_ID_RESET = 16'h0001;

    typedef logic [SLOT_W-1:0] t_slot;
    localparam t_slot SLOT_LAST = t_slot'(INSTANCE_SLOTS - 1);

    typedef enum logic [2:0] {
        MSG_NONE    = 3'd0,
        MSG_PHASE1B = 3'd2,
        MSG_PHASE2B = 3'd4
    } t_msg_type;

    typedef enum logic {
        OP_PREPARE = 1'b0,
        OP_ACCEPT  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

    typedef struct packed {
        logic [0:0]  operation;
        logic [15:0] instance_req;
        logic [15:0] round;
        logic [15:0] voted_round_in;
        logic [63:0] value_w01;
        logic [63:0] value_w23;
        logic [63:0] value_w45;
        logic [63:0] value_w67;
    } t_req;

    typedef struct packed {
        logic [0:0]  forward;
        logic [2:0]  message_type;
        logic [15:0] instance_out;
        logic [15:0] round_out;
        logic [15:0] voted_round_out;
        logic [15:0] acceptor_out;
        logic [63:0] value_o01;
        logic [63:0] value_o23;
        logic [63:0] value_o45;
        logic [63:0] value_o67;
    } t_rsp;

    typedef struct packed {
        t_op         op;
        t_slot       slot;
        logic [15:0] inst;
        logic [15:0] rnd;
        logic [15:0] vrnd;
        logic [63:0] v01;
        logic [63:0] v23;
        logic [63:0] v45;
        logic [63:0] v67;
    } t_cmd;

    typedef struct packed {
        logic [15:0] promised;
        logic [15:0] voted;
        logic [63:0] v01;
        logic [63:0] v23;
        logic [63:0] v45;
        logic [63:0] v67;
    } t_entry;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_status;

    function automatic t_slot slot_of(logic [15:0] inst);
        logic [SLOT_W+15:0] ext;
        ext = {{SLOT_W{1'b0}}, inst};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

>>> src/pat_front.sv
// Front end of the acceptor table: two-entry input queue that decodes each
// message into a table command. Depends on pat_pkg.
module pat_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  pat_pkg::t_req        i_req,
    input  pat_pkg::t_back_status i_status,
    output logic                 o_cmd_valid,
    output pat_pkg::t_cmd        o_cmd
);
    import pat_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    t_cmd       cmd_in;

    assign full    = (r_count == 2'd2) || i_status.clearing;
    assign do_push = push && !full;

    always_comb begin
        cmd_in.op   = t_op'(i_req.operation);
        cmd_in.slot = slot_of(i_req.instance_req);
        cmd_in.inst = i_req.instance_req;
        cmd_in.rnd  = i_req.round;
        cmd_in.vrnd = i_req.voted_round_in;
        cmd_in.v01  = i_req.value_w01;
        cmd_in.v23  = i_req.value_w23;
        cmd_in.v45  = i_req.value_w45;
        cmd_in.v67  = i_req.value_w67;
    end

    always_comb begin
        n_count = r_count;
        if (do_push && !i_status.take) begin
            n_count = r_count + 2'd1;
        end else if (!do_push && i_status.take) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_status.take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

endmodule

>>> src/pat_back.sv
// Back end of the acceptor table: instance table memory, read-compare-write
// sequencer, clearing sweep after reset and two-entry result queue.
// Depends on pat_pkg.
module pat_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  pat_pkg::t_cmd         i_cmd,
    output pat_pkg::t_back_status o_status,
    input  logic [15:0]           i_acceptor_id,
    output logic                  empty,
    input  logic                  pop,
    output pat_pkg::t_rsp         o_rsp
);
    import pat_pkg::*;

    t_entry      r_mem [INSTANCE_SLOTS];
    t_entry      r_rd;
    t_back_state r_state, n_state;
    t_slot       r_clr_cnt;
    t_cmd        r_cmd;

    logic        take;
    logic        we;
    t_slot       wa;
    t_entry      wd;
    logic        stale;
    t_rsp        rsp_new;
    logic        rsp_push;

    t_rsp        r_oq [2];
    logic        r_owr, r_ord;
    logic [1:0]  r_ocount, n_ocount;
    logic        do_pop;

    assign stale = (r_cmd.rnd < r_rd.promised);

    always_comb begin
        n_state  = r_state;
        take     = 1'b0;
        we       = 1'b0;
        wa       = r_cmd.slot;
        wd       = '0;
        rsp_push = 1'b0;
        rsp_new  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                wa = r_clr_cnt;
                if (r_clr_cnt == SLOT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && (r_ocount != 2'd2)) begin
                    take    = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                rsp_push = 1'b1;
                n_state  = ST_IDLE;
                if (!stale) begin
                    we                      = 1'b1;
                    rsp_new.forward         = 1'b1;
                    rsp_new.instance_out    = r_cmd.inst;
                    rsp_new.round_out       = r_cmd.rnd;
                    rsp_new.acceptor_out    = i_acceptor_id;
                    wd.promised             = r_cmd.rnd;
                    if (r_cmd.op == OP_ACCEPT) begin
                        wd.voted                = r_cmd.rnd;
                        wd.v01                  = r_cmd.v01;
                        wd.v23                  = r_cmd.v23;
                        wd.v45                  = r_cmd.v45;
                        wd.v67                  = r_cmd.v67;
                        rsp_new.message_type    = MSG_PHASE2B;
                        rsp_new.voted_round_out = r_cmd.vrnd;
                    end else begin
                        wd.voted                = r_rd.voted;
                        wd.v01                  = r_rd.v01;
                        wd.v23                  = r_rd.v23;
                        wd.v45                  = r_rd.v45;
                        wd.v67                  = r_rd.v67;
                        rsp_new.message_type    = MSG_PHASE1B;
                        rsp_new.voted_round_out = r_rd.voted;
                    end
                    rsp_new.value_o01 = wd.v01;
                    rsp_new.value_o23 = wd.v23;
                    rsp_new.value_o45 = wd.v45;
                    rsp_new.value_o67 = wd.v67;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + t_slot'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd <= r_mem[i_cmd.slot];
        end
    end

    assign o_status.take     = take;
    assign o_status.clearing = (r_state == ST_CLEAR);

    // result queue
    assign do_pop = pop && !empty;

    always_comb begin
        n_ocount = r_ocount;
        if (rsp_push && !do_pop) begin
            n_ocount = r_ocount + 2'd1;
        end else if (!rsp_push && do_pop) begin
            n_ocount = r_ocount - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocount <= 2'd0;
            r_owr    <= 1'b0;
            r_ord    <= 1'b0;
        end else begin
            r_ocount <= n_ocount;
            if (rsp_push) begin
                r_owr <= ~r_owr;
            end
            if (do_pop) begin
                r_ord <= ~r_ord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_push) begin
            r_oq[r_owr] <= rsp_new;
        end
    end

    assign empty = (r_ocount == 2'd0);
    assign o_rsp = r_oq[r_ord];

endmodule

>>> src/paxos_acceptor_table_core.sv
// Top level of the Paxos acceptor table: configuration register port and the
// front and back halves. Depends on pat_pkg, pat_front and pat_back.
//
// Each message passes the back end in order: IDLE reads its instance slot
// from the single-ported-read table, then EXEC compares the round and
// writes the slot back; no new message is taken until that write is done.
// A decoded input queue and a result queue, two items each, let both sides
// stall on their own. After reset the table is swept to zero one slot per
// cycle; full stays high until the sweep ends, while the acceptor id
// register can be written at any time.
module paxos_acceptor_table_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  pat_pkg::t_req              i_req,
    output logic                       empty,
    input  logic                       pop,
    output pat_pkg::t_rsp              o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pat_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pat_pkg::*;

    logic         [15:0] r_acceptor_id;
    logic                cmd_valid;
    t_cmd                cmd;
    t_back_status        status;
    logic                id_sel;

    assign pready = 1'b1;
    assign id_sel = (paddr[PADDR_W-1] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acceptor_id <= ACCEPTOR_ID_RESET;
        end else if (psel && penable && pwrite && pready && id_sel) begin
            r_acceptor_id <= pwdata[15:0];
        end
    end

    assign prdata = id_sel ? {16'd0, r_acceptor_id} : 32'd0;

    pat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .i_status    (status),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    pat_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_acceptor_id (r_acceptor_id),
        .empty         (empty),
        .pop           (pop),
        .o_rsp         (o_rsp)
    );

endmodule
